/* sv/bhs_pkg.sv */
// Shared constants, widths and control/status bundles of the bucketed hash set.
package bhs_pkg;

   // Geometry of the set
   localparam int NUM_BUCKETS  = 128;
   localparam int BUCKET_SLOTS = 8;
   localparam int KEY_BITS     = 32;

   // Port field widths
   localparam int MODE_W      = 2;
   localparam int KEY_IN_W    = 32;
   localparam int FILL_OUT_W  = 4;
   localparam int RSP_DATA_W  = 8;

   // Derived widths
   localparam int SKEY_W      = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
   localparam int BUCKET_W    = $clog2(NUM_BUCKETS);
   localparam int CNT_W       = $clog2(BUCKET_SLOTS + 1);
   localparam int SLOT_ADDR_W = $clog2(NUM_BUCKETS * BUCKET_SLOTS);
   localparam int DIGITS      = (SKEY_W + 7) / 8;
   localparam int PAD_W       = DIGITS * 8;
   localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);
   localparam int RED_W       = BUCKET_W + 8;
   localparam bit BUCKET_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

   // Operation codes
   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture request, start bucket reduction
      logic clr;        // clear one fill count
      logic cnt_rd;     // read fill count, compute slot base
      logic fill_load;  // take fill count, start scan
      logic scan;       // scan one slot per cycle
      logic update;     // write back count, append key, read last slot
      logic move;       // move last slot into the freed place
      logic out_load;   // load result register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clr_done;
      logic mod_done;
      logic scan_done;
      logic do_move;
      logic out_free;
   } sts_type;

endpackage

/* sv/bhs_mod.sv */
// Key modulo the bucket count: low bits if a power of two, else digit-serial reduction.
module bhs_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bhs_pkg::SKEY_W-1:0]    key,
   output logic [bhs_pkg::BUCKET_W-1:0]  bucket,
   output logic                          done
);

   logic [bhs_pkg::PAD_W-1:0]       key_sh_ff, key_sh_in;
   logic [bhs_pkg::BUCKET_W-1:0]    rem_ff, rem_in;
   logic [bhs_pkg::DIGIT_CNT_W-1:0] left_ff, left_in;

   // Fold one byte into the remainder: rem*256 + digit, reduced by restoring subtraction
   function automatic logic [bhs_pkg::BUCKET_W-1:0] fold_digit(
      input logic [bhs_pkg::BUCKET_W-1:0] rem,
      input logic [7:0]                   digit
   );
      logic [bhs_pkg::RED_W-1:0] acc;
      logic [bhs_pkg::RED_W-1:0] sub;
      acc = {rem, digit};
      for (int k = 7; k >= 0; k--) begin
         sub = bhs_pkg::RED_W'(bhs_pkg::NUM_BUCKETS) << k;
         if (acc >= sub) begin
            acc = acc - sub;
         end
      end
      return acc[bhs_pkg::BUCKET_W-1:0];
   endfunction

   // Load the key, then, for a non-pow2 count, consume one byte per cycle from the top
   always_comb begin
      key_sh_in = key_sh_ff;
      rem_in    = rem_ff;
      left_in   = left_ff;
      if (start) begin
         key_sh_in = bhs_pkg::PAD_W'(key);
         if (bhs_pkg::BUCKET_POW2) begin
            rem_in  = bhs_pkg::BUCKET_W'(key);
            left_in = '0;
         end else begin
            rem_in  = '0;
            left_in = bhs_pkg::DIGIT_CNT_W'(bhs_pkg::DIGITS);
         end
      end else if (left_ff != '0) begin
         rem_in    = fold_digit(rem_ff, key_sh_ff[bhs_pkg::PAD_W-1 -: 8]);
         key_sh_in = key_sh_ff << 8;
         left_in   = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
      key_sh_ff <= key_sh_in;
      rem_ff    <= rem_in;
   end

   assign bucket = rem_ff;
   assign done   = (left_ff == '0);

endmodule

/* sv/bhs_datapath.sv */
// Datapath: key and count memories, slot scan, update and result register.
module bhs_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  bhs_pkg::cmd_type                 cmd,
   output bhs_pkg::sts_type                 sts,
   input  logic [bhs_pkg::MODE_W-1:0]       req_mode,
   input  logic [bhs_pkg::KEY_IN_W-1:0]     req_key,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic [bhs_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int NUM_SLOTS = bhs_pkg::NUM_BUCKETS * bhs_pkg::BUCKET_SLOTS;

   // Memories
   logic [bhs_pkg::SKEY_W-1:0] slot_mem [NUM_SLOTS];
   logic [bhs_pkg::CNT_W-1:0]  cnt_mem  [bhs_pkg::NUM_BUCKETS];

   logic [bhs_pkg::SKEY_W-1:0]      slot_rdata_ff;
   logic [bhs_pkg::CNT_W-1:0]       cnt_rdata_ff;

   // Request and scan state
   logic [bhs_pkg::MODE_W-1:0]      mode_ff, mode_in;
   logic [bhs_pkg::SKEY_W-1:0]      key_ff, key_in;
   logic [bhs_pkg::SLOT_ADDR_W-1:0] base_ff, base_in;
   logic [bhs_pkg::CNT_W-1:0]       fill_ff, fill_in;
   logic [bhs_pkg::CNT_W-1:0]       idx_ff, idx_in;
   logic [bhs_pkg::CNT_W-1:0]       pos_ff, pos_in;
   logic                            pend_ff, pend_in;
   logic                            found_ff, found_in;
   logic                            status_ff, status_in;
   logic [bhs_pkg::BUCKET_W-1:0]    clr_idx_ff, clr_idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bhs_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [bhs_pkg::SKEY_W-1:0]      key_masked;
   logic [bhs_pkg::BUCKET_W-1:0]    bucket;
   logic                            mod_done;
   logic                            match;
   logic                            scan_done;
   logic                            rd_issue;
   logic                            is_add;
   logic                            is_rem;
   logic                            full;
   logic                            add_wr;
   logic                            add_drop;
   logic                            rem_hit;
   logic [bhs_pkg::CNT_W-1:0]       new_fill;
   logic [bhs_pkg::SLOT_ADDR_W-1:0] slot_raddr;
   logic [bhs_pkg::SLOT_ADDR_W-1:0] slot_waddr;
   logic [bhs_pkg::SKEY_W-1:0]      slot_wdata;
   logic                            slot_we;
   logic [bhs_pkg::BUCKET_W-1:0]    cnt_addr;
   logic [bhs_pkg::CNT_W-1:0]       cnt_wdata;
   logic                            cnt_we;
   logic                            out_free;

   function automatic logic [bhs_pkg::SKEY_W-1:0] key_ff_src(
      input logic [bhs_pkg::KEY_IN_W-1:0] k
   );
      return k[bhs_pkg::SKEY_W-1:0];
   endfunction

   assign key_masked = key_ff_src(req_key);

   // Bucket index from the key
   bhs_mod u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.load),
      .key    (key_masked),
      .bucket (bucket),
      .done   (mod_done)
   );

   // Scan compare and operation decode
   always_comb begin
      match     = pend_ff && (slot_rdata_ff == key_ff);
      scan_done = match || (idx_ff == fill_ff);
      rd_issue  = cmd.scan && !scan_done;
      is_add    = (mode_ff == bhs_pkg::MODE_ADD);
      is_rem    = (mode_ff == bhs_pkg::MODE_REMOVE);
      full      = (fill_ff == bhs_pkg::CNT_W'(bhs_pkg::BUCKET_SLOTS));
      add_wr    = is_add && !found_ff && !full;
      add_drop  = is_add && !found_ff && full;
      rem_hit   = is_rem && found_ff;
      if (add_wr) begin
         new_fill = fill_ff + 1'b1;
      end else if (rem_hit) begin
         new_fill = fill_ff - 1'b1;
      end else begin
         new_fill = fill_ff;
      end
      out_free  = !rsp_valid_ff || rsp_tready;
   end

   // Memory port selection
   always_comb begin
      if (cmd.update) begin
         slot_raddr = base_ff + bhs_pkg::SLOT_ADDR_W'(fill_ff - 1'b1);
      end else begin
         slot_raddr = base_ff + bhs_pkg::SLOT_ADDR_W'(idx_ff);
      end
      slot_we = (cmd.update && add_wr) || cmd.move;
      if (cmd.move) begin
         slot_waddr = base_ff + bhs_pkg::SLOT_ADDR_W'(pos_ff);
         slot_wdata = slot_rdata_ff;
      end else begin
         slot_waddr = base_ff + bhs_pkg::SLOT_ADDR_W'(fill_ff);
         slot_wdata = key_ff;
      end
      cnt_we = cmd.clr || cmd.update;
      if (cmd.clr) begin
         cnt_addr  = clr_idx_ff;
         cnt_wdata = '0;
      end else begin
         cnt_addr  = bucket;
         cnt_wdata = new_fill;
      end
   end

   // Next values of the working registers
   always_comb begin
      mode_in      = mode_ff;
      key_in       = key_ff;
      base_in      = base_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      pend_in      = pend_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      clr_idx_in   = clr_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         mode_in = req_mode;
         key_in  = key_masked;
      end
      if (cmd.clr) begin
         clr_idx_in = clr_idx_ff + 1'b1;
      end
      if (cmd.cnt_rd) begin
         base_in = bhs_pkg::SLOT_ADDR_W'(bucket * bhs_pkg::BUCKET_SLOTS);
      end
      if (cmd.fill_load) begin
         fill_in  = cnt_rdata_ff;
         idx_in   = '0;
         pend_in  = 1'b0;
         found_in = 1'b0;
      end
      if (cmd.scan) begin
         pend_in = rd_issue;
         if (rd_issue) begin
            idx_in = idx_ff + 1'b1;
         end
         if (match) begin
            found_in = 1'b1;
            pos_in   = idx_ff - 1'b1;
         end
      end
      if (cmd.update) begin
         fill_in   = new_fill;
         status_in = add_drop;
      end

      // Result register: drain on accept, reload when the controller finishes
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = bhs_pkg::RSP_DATA_W'(
                           {bhs_pkg::FILL_OUT_W'(fill_ff), status_ff, found_ff});
      end
   end

   // Key memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rdata_ff <= slot_mem[slot_raddr];
   end

   // Fill count memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_addr] <= cnt_wdata;
      end
      cnt_rdata_ff <= cnt_mem[bucket];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      base_ff     <= base_in;
      fill_ff     <= fill_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Status to the controller
   always_comb begin
      sts.clr_done  = (clr_idx_ff == bhs_pkg::BUCKET_W'(bhs_pkg::NUM_BUCKETS - 1));
      sts.mod_done  = mod_done;
      sts.scan_done = scan_done;
      sts.do_move   = rem_hit;
      sts.out_free  = out_free;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* sv/bhs_ctrl.sv */
// Controller: sequences clear pass, reduction, count read, scan, update, move and result.
module bhs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  bhs_pkg::sts_type sts,
   output bhs_pkg::cmd_type cmd
);

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_MOD      = 4'd2;
   localparam logic [3:0] ST_CNT_RD   = 4'd3;
   localparam logic [3:0] ST_CNT_WAIT = 4'd4;
   localparam logic [3:0] ST_SCAN     = 4'd5;
   localparam logic [3:0] ST_UPDATE   = 4'd6;
   localparam logic [3:0] ST_MOVE     = 4'd7;
   localparam logic [3:0] ST_DONE     = 4'd8;

   logic [3:0] state_ff, state_in;

   // Decode state into commands and pick the next state
   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               state_in = ST_CNT_RD;
            end
         end
         ST_CNT_RD: begin
            cmd.cnt_rd = 1'b1;
            state_in   = ST_CNT_WAIT;
         end
         ST_CNT_WAIT: begin
            cmd.fill_load = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = sts.do_move ? ST_MOVE : ST_DONE;
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/bucketed_hash_set_unit.sv */
// Top level of the bucketed hash set: controller plus datapath.
//
//  channel | direction | tdata (low bit up)                      | tuser
//  req_    | in        | key[31:0]                               | mode[1:0]
//  rsp_    | out       | was_present, status, bucket_fill[3:0], 0 | -
//
// One request at a time: the key is reduced to a bucket (byte by byte unless the count is a
// power of two), the fill count is read, the slots are scanned to a match or the end,
// the count is written back, a remove that hits moves the last slot into the hole, and the
// result is loaded. The scan reads one slot per cycle through one read port. After reset a
// clearing pass zeroes the NUM_BUCKETS fill counts (128 here) with req_tready low. A stalled
// result holds in the output register while the next request runs.
module bucketed_hash_set_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bhs_pkg::KEY_IN_W-1:0]    req_tdata,   // key
   input  logic [bhs_pkg::MODE_W-1:0]      req_tuser,   // mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bhs_pkg::RSP_DATA_W-1:0]  rsp_tdata    // was_present, status, bucket_fill
);

   bhs_pkg::cmd_type cmd;
   bhs_pkg::sts_type sts;

   bhs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bhs_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_mode   (req_tuser),
      .req_key    (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* sv/bhs_checker.sv */
// Port-level checks of the bucketed hash set, bound to the top level.
module bhs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bhs_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // A dropped add never reports a present key
   a_drop_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> !rsp_tdata[0])
      else $error("dropped add reported a present key");

   // A dropped add reports a full bucket
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[5:2] == 4'(bhs_pkg::BUCKET_SLOTS))
      else $error("dropped add without a full bucket");

   // Reset empties the output and starts the clearing pass
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("block active right after reset");

endmodule

bind bucketed_hash_set_unit bhs_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/sv/tb_bucketed_hash_set_unit.sv */
// Self-checking testbench for the bucketed hash set unit: directed and random requests.
`timescale 1ns / 1ps

module tb_bucketed_hash_set_unit;

   // Codes the package leaves unnamed
   localparam logic [bhs_pkg::MODE_W-1:0] MODE_QUERY = 2'd2;
   localparam logic [bhs_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

   localparam int NUM_SLOTS   = bhs_pkg::NUM_BUCKETS * bhs_pkg::BUCKET_SLOTS;
   localparam int HOT_COUNT   = 4;
   localparam int UPPER_COUNT = 12;

   typedef struct {
      logic                           was_present;
      logic                           status;
      logic [bhs_pkg::FILL_OUT_W-1:0] bucket_fill;
   } set_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [bhs_pkg::KEY_IN_W-1:0]    req_tdata = '0;   // key
   logic [bhs_pkg::MODE_W-1:0]      req_tuser = '0;   // mode
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [bhs_pkg::RSP_DATA_W-1:0]  rsp_tdata;  // was_present, status, bucket_fill[3:0], pad

   // Shadow copy of the set
   logic [bhs_pkg::SKEY_W-1:0]      shadow_keys [NUM_SLOTS];
   int                              shadow_fill [bhs_pkg::NUM_BUCKETS];

   set_result_type                  pending_results[$];
   int                              mismatch_count = 0;
   int                              send_idle_pct = 0;
   int                              rsp_stall_pct = 0;
   int                              hold_request = 0;
   int                              hold_left = 0;

   logic [bhs_pkg::KEY_IN_W-1:0]    hot_buckets [HOT_COUNT];
   logic [bhs_pkg::KEY_IN_W-1:0]    upper_keys [UPPER_COUNT];

   bucketed_hash_set_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Apply one operation to the shadow set and return what the block must report
   function automatic set_result_type apply_set_op(
      input logic [bhs_pkg::MODE_W-1:0]   mode,
      input logic [bhs_pkg::KEY_IN_W-1:0] key_in
   );
      set_result_type             res;
      logic [bhs_pkg::SKEY_W-1:0] key;
      int                         bucket;
      int                         base;
      int                         fill;
      int                         hit_pos;
      bit                         found;
      key     = key_in[bhs_pkg::SKEY_W-1:0];
      bucket  = int'(key % bhs_pkg::NUM_BUCKETS);
      base    = bucket * bhs_pkg::BUCKET_SLOTS;
      fill    = shadow_fill[bucket];
      found   = 1'b0;
      hit_pos = 0;
      res.status = 1'b0;
      for (int i = 0; i < fill; i++) begin
         if (!found && shadow_keys[base + i] == key) begin
            found   = 1'b1;
            hit_pos = i;
         end
      end
      if (mode == bhs_pkg::MODE_ADD) begin
         if (!found) begin
            if (fill < bhs_pkg::BUCKET_SLOTS) begin
               shadow_keys[base + fill] = key;
               fill++;
            end else begin
               res.status = 1'b1;
            end
         end
      end else if (mode == bhs_pkg::MODE_REMOVE) begin
         // fill the hole with the last slot
         if (found) begin
            shadow_keys[base + hit_pos] = shadow_keys[base + fill - 1];
            fill--;
         end
      end
      shadow_fill[bucket] = fill;
      res.was_present = found;
      res.bucket_fill = bhs_pkg::FILL_OUT_W'(fill);
      return res;
   endfunction

   // Offer one request after a random gap and record its outcome once accepted
   task automatic send_request(input logic [bhs_pkg::MODE_W-1:0]   mode,
                               input logic [bhs_pkg::KEY_IN_W-1:0] key);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.insert(pending_results.size(), apply_set_op(mode, key));
   endtask

   // Hold the sender until every outstanding result has been taken
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Take results and check them against the shadow set
   always @(posedge clock) begin
      set_result_type exp_res;
      if (rsp_tvalid && rsp_tready && !reset) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result tdata=%h", $realtime, rsp_tdata);
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_tdata[0] !== exp_res.was_present || rsp_tdata[1] !== exp_res.status ||
                rsp_tdata[5:2] !== exp_res.bucket_fill) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result mismatch exp present=%b status=%b fill=%0d, %s %b %b %0d",
                           $realtime, exp_res.was_present, exp_res.status,
                           exp_res.bucket_fill, "got",
                           rsp_tdata[0], rsp_tdata[1], rsp_tdata[5:2]);
            end
         end
      end
   end

   // Drive rsp_tready: random stalls, or a long hold counted in cycles when one is requested
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Edge cases: empty set, extreme keys, spare mode, a full bucket and a remove that moves
   task automatic test_directed();
      logic [bhs_pkg::KEY_IN_W-1:0] fkey;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_request(MODE_QUERY, 32'h0000_0000);
      send_request(bhs_pkg::MODE_ADD, 32'h0000_0000);
      send_request(bhs_pkg::MODE_ADD, 32'h0000_0000);
      send_request(bhs_pkg::MODE_ADD, 32'hFFFF_FFFF);
      send_request(MODE_QUERY, 32'hFFFF_FFFF);
      send_request(bhs_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
      send_request(bhs_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
      send_request(MODE_SPARE, 32'h0000_0000);
      for (int i = 0; i < bhs_pkg::BUCKET_SLOTS; i++) begin
         fkey = (bhs_pkg::KEY_IN_W'(i) << 25) | (bhs_pkg::KEY_IN_W'(i) << 7) |
                bhs_pkg::KEY_IN_W'(5);
         send_request(bhs_pkg::MODE_ADD, fkey);
      end
      send_request(bhs_pkg::MODE_ADD, 32'hAAAA_AA85);
      send_request(bhs_pkg::MODE_ADD, 32'h0000_0085);
      send_request(bhs_pkg::MODE_REMOVE, 32'h0000_0105 | (32'd2 << 25));
      send_request(MODE_QUERY, (bhs_pkg::KEY_IN_W'(bhs_pkg::BUCKET_SLOTS - 1) << 25) |
                               (bhs_pkg::KEY_IN_W'(bhs_pkg::BUCKET_SLOTS - 1) << 7) |
                               bhs_pkg::KEY_IN_W'(5));
      send_request(MODE_QUERY, 32'h0000_0105 | (32'd2 << 25));
      send_request(MODE_SPARE, 32'h0000_0005);
      wait_for_results();
   endtask

   // Random mix on a few hot buckets, with some fully random keys
   task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
      logic [bhs_pkg::MODE_W-1:0]   mode;
      logic [bhs_pkg::KEY_IN_W-1:0] key;
      int                           pick;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < HOT_COUNT; i++)
         hot_buckets[i] = $urandom_range(bhs_pkg::NUM_BUCKETS - 1);
      hot_buckets[0] = ($urandom_range(1) != 0) ?
                       bhs_pkg::KEY_IN_W'(bhs_pkg::NUM_BUCKETS - 1) : '0;
      for (int i = 0; i < UPPER_COUNT; i++) upper_keys[i] = $urandom();
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 45)      mode = bhs_pkg::MODE_ADD;
         else if (pick < 70) mode = bhs_pkg::MODE_REMOVE;
         else if (pick < 94) mode = MODE_QUERY;
         else                mode = MODE_SPARE;
         if ($urandom_range(99) < 10)
            key = $urandom();
         else
            key = upper_keys[$urandom_range(UPPER_COUNT - 1)] * bhs_pkg::NUM_BUCKETS +
                  hot_buckets[$urandom_range(HOT_COUNT - 1)];
         send_request(mode, key);
      end
      wait_for_results();
   endtask

   // Stall the result side for a long stretch while requests keep coming
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = 300;
      for (int n = 0; n < 40; n++)
         send_request(($urandom_range(1) != 0) ? bhs_pkg::MODE_ADD : MODE_QUERY,
                      ($urandom() & 32'hFFFF_FF80) | bhs_pkg::KEY_IN_W'(9));
      wait_for_results();
   endtask

   initial begin
      for (int i = 0; i < bhs_pkg::NUM_BUCKETS; i++) shadow_fill[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phase(400, 0, 0);
      test_random_phase(400, 79, 0);
      test_backpressure();
      test_random_phase(400, 0, 79);
      test_random_phase(390, 23, 23);
      rsp_stall_pct = 0;
      wait_for_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Give up if the run hangs
   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
